// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

// File: hw/rtl/jlaot_pkg.sv
// Shared types and constants of the altitude offset tracker.
package jlaot_pkg;
	localparam int unsigned IN_W    = 25;
	localparam int unsigned POS_W   = 48;
	localparam int unsigned VEL_W   = 32;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned OPOS_W  = 33;
	localparam int unsigned OVEL_W  = 19;
	localparam int unsigned OACC_W  = 18;
	localparam int unsigned CFG_W   = 17;
	localparam int unsigned CIDX_W  = 2;
	localparam logic [CIDX_W-1:0] REG_AMAX  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_CLIMB = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DESC  = 2'd2;
	localparam logic [CIDX_W-1:0] REG_DT    = 2'd3;

	// Datapath operations issued by the controller.
	localparam int unsigned OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_ROOTP = 4'd2;
	localparam logic [OP_W-1:0] OP_ROOT  = 4'd3;
	localparam logic [OP_W-1:0] OP_VT    = 4'd4;
	localparam logic [OP_W-1:0] OP_JD    = 4'd5;
	localparam logic [OP_W-1:0] OP_ACC   = 4'd6;
	localparam logic [OP_W-1:0] OP_DV    = 4'd8;
	localparam logic [OP_W-1:0] OP_DP1   = 4'd9;
	localparam logic [OP_W-1:0] OP_DP2   = 4'd10;
	localparam logic [OP_W-1:0] OP_UPD   = 4'd11;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            div_start;
	} jlaot_cmd_t;

	typedef struct packed {
		logic root_busy;
		logic div_busy;
	} jlaot_sts_t;
endpackage

// File: hw/rtl/jlaot_datapath.sv
// Datapath: error, square root, limits, multiplies and division by one million.
module jlaot_datapath #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jlaot_pkg::jlaot_cmd_t            cmd,
	output jlaot_pkg::jlaot_sts_t            sts,
	input  logic signed [jlaot_pkg::IN_W-1:0] alt,
	input  logic [8:0]                       amax,
	input  logic [9:0]                       climb,
	input  logic [8:0]                       desc,
	input  logic [16:0]                      dt,
	output logic signed [jlaot_pkg::OPOS_W-1:0] pos_o,
	output logic signed [jlaot_pkg::OVEL_W-1:0] vel_o,
	output logic signed [jlaot_pkg::OACC_W-1:0] acc_o
);
	localparam int unsigned SH = FRAC_BITS - 8;
	// Wide signed working width; products fit in 80 bits.
	localparam int unsigned W = 80;
	localparam int unsigned DW = 21 + FRAC_BITS + 1;
	localparam int unsigned PW = 11 + DW;
	localparam int unsigned RADW = 2 * (PW + FRAC_BITS);
	localparam int unsigned RTW = RADW / 2;
	// Dividend magnitude stays below 2^DIVW; the reciprocal is exact over that range.
	localparam int unsigned DIVW = 56;
	localparam int unsigned RSH = 76;
	localparam int unsigned RCPW = 57;
	localparam int unsigned ACCW = DIVW + RCPW;
	localparam int unsigned MILLION = 1000000;
	localparam logic [RCPW-1:0] RECIP =
		RCPW'(((77'(1) << RSH) + 77'(MILLION - 1)) / 77'(MILLION));

	logic signed [jlaot_pkg::POS_W-1:0] pos_q;
	logic signed [jlaot_pkg::VEL_W-1:0] vel_q;
	logic signed [jlaot_pkg::ACC_W-1:0] acc_q;
	logic signed [W-1:0] e_q, vt_q, jd_q, dv_q, dp_q, t_q;
	logic [PW-1:0]   p_q;
	logic [RADW-1:0] rad_q;
	logic [RTW-1:0]  root_q;
	logic [RTW+1:0]  rem_q;
	logic [7:0]      rcnt_q;
	logic            rbusy_q;
	logic            lin_q;

	// Division by 1e6 as a multiply by the scaled reciprocal, one 32x32 partial
	// product per cycle. A negative dividend is biased by 1e6-1 so the negated
	// quotient rounds toward minus infinity.
	logic [DIVW-1:0] dnum_q;
	logic [ACCW-1:0] dacc_q;
	logic [1:0]      dstep_q;
	logic            dbusy_q, dneg_q;
	logic [31:0]     mop_a, mop_b;
	logic [63:0]     mprod;
	logic [ACCW-1:0] mterm;
	logic signed [W-1:0] quot;

	logic signed [W-1:0] mag, lin, d, one_m, amx, lo, hi, acmd, anew, vmax, vmin;
	logic signed [W-1:0] p_vel, p_pos, n_vel, n_pos;
	logic [RTW+1:0] rtrial, rshift;

	function automatic logic signed [W-1:0] satw(input logic signed [W-1:0] x,
		input int unsigned w);
		logic signed [W-1:0] h;
		logic signed [W-1:0] l;
		h = (W'(1) <<< (w - 1)) - W'(1);
		l = -h - W'(1);
		if (x > h) return h;
		if (x < l) return l;
		return x;
	endfunction

	assign one_m = W'(1) <<< FRAC_BITS;
	assign amx   = W'(amax) * one_m;
	assign mag   = e_q < 0 ? -e_q : e_q;
	assign lin   = W'(3) * amx;
	always_comb begin
		d = mag - (lin >>> 1);
		if (d > (W'(1) <<< (21 + FRAC_BITS))) d = W'(1) <<< (21 + FRAC_BITS);
	end
	assign vmax = W'(climb) * one_m;
	assign vmin = -(W'(desc) * one_m);
	always_comb begin
		lo = W'(acc_q) - jd_q;
		if (lo < -amx) lo = -amx;
		hi = W'(acc_q) + jd_q;
		if (hi > amx) hi = amx;
		acmd = W'(2) * (vt_q - W'(vel_q));
		if (acmd < lo) anew = lo;
		else if (acmd > hi) anew = hi;
		else anew = acmd;
	end
	always_comb begin
		mop_a = dstep_q[1] ? 32'(dnum_q[DIVW-1:32]) : dnum_q[31:0];
		mop_b = dstep_q[0] ? 32'(RECIP[RCPW-1:32]) : RECIP[31:0];
		mprod = mop_a * mop_b;
		case (dstep_q) inside
			2'd0:       mterm = ACCW'(mprod);
			2'd1, 2'd2: mterm = ACCW'(mprod) << 32;
			default:    mterm = ACCW'(mprod) << 64;
		endcase
	end
	assign quot = dneg_q ? -W'(dacc_q[ACCW-1:RSH]) : W'(dacc_q[ACCW-1:RSH]);
	assign rshift = {rem_q[RTW-1:0], rad_q[RADW-1 -: 2]};
	assign rtrial = {root_q, 2'b01};
	assign n_pos = satw(W'(pos_q) + dp_q, jlaot_pkg::POS_W);
	assign n_vel = satw(W'(vel_q) + dv_q, jlaot_pkg::VEL_W);
	assign p_pos = W'(pos_q) >>> SH;
	assign p_vel = W'(vel_q) >>> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; vel_q <= '0; acc_q <= '0;
			rbusy_q <= 1'b0; dbusy_q <= 1'b0; rcnt_q <= '0; dstep_q <= '0;
		end else begin
			if (cmd.div_start) begin
				dbusy_q <= 1'b1; dstep_q <= '0;
				dneg_q  <= t_q < 0;
				dnum_q  <= DIVW'(t_q < 0 ? -t_q + W'(MILLION - 1) : t_q);
				dacc_q  <= '0;
			end else if (dbusy_q) begin
				dacc_q  <= dacc_q + mterm;
				dstep_q <= dstep_q + 2'd1;
				if (dstep_q == 2'd3) dbusy_q <= 1'b0;
			end
			if (rbusy_q) begin
				if (rshift >= rtrial) begin
					rem_q  <= rshift - rtrial;
					root_q <= {root_q[RTW-2:0], 1'b1};
				end else begin
					rem_q  <= rshift;
					root_q <= {root_q[RTW-2:0], 1'b0};
				end
				rad_q  <= rad_q << 2;
				rcnt_q <= rcnt_q - 8'd1;
				if (rcnt_q == 8'd1) rbusy_q <= 1'b0;
			end
			unique case (cmd.op)
				jlaot_pkg::OP_LOAD: begin
					e_q <= W'(pos_q) + (W'(alt) <<< FRAC_BITS);
				end
				jlaot_pkg::OP_ROOTP: begin
					lin_q <= mag <= lin;
					p_q   <= PW'(W'(3) * W'(amax)) * PW'(d);
				end
				jlaot_pkg::OP_ROOT: begin
					rad_q   <= RADW'(p_q) << (FRAC_BITS - 1 + 1) >> 1 << 1 >> 1;
					rem_q   <= '0; root_q <= '0;
					rbusy_q <= !lin_q; rcnt_q <= 8'(RTW);
				end
				jlaot_pkg::OP_VT: begin
					if (lin_q) vt_q <= e_q >>> 1;
					else vt_q <= e_q < 0 ? -W'(root_q) : W'(root_q);
					t_q <= W'(2) * amx * W'(dt);
				end
				jlaot_pkg::OP_JD: begin
					if (vt_q > vmax) vt_q <= vmax;
					else if (vt_q < vmin) vt_q <= vmin;
					jd_q <= quot;
				end
				jlaot_pkg::OP_ACC: begin
					acc_q <= jlaot_pkg::ACC_W'(satw(anew, jlaot_pkg::ACC_W));
					t_q   <= satw(anew, jlaot_pkg::ACC_W) * W'(dt);
				end
				jlaot_pkg::OP_DV: begin
					dv_q <= quot;
					t_q  <= quot * W'(dt);
				end
				jlaot_pkg::OP_DP1: begin
					dp_q <= quot;
					t_q  <= W'(vel_q) * W'(dt);
				end
				jlaot_pkg::OP_DP2: begin
					dp_q <= dp_q + quot;
				end
				jlaot_pkg::OP_UPD: begin
					pos_q <= jlaot_pkg::POS_W'(n_pos);
					vel_q <= jlaot_pkg::VEL_W'(n_vel);
				end
				default: ;
			endcase
		end
	end

	assign pos_o = jlaot_pkg::OPOS_W'(satw(p_pos, jlaot_pkg::OPOS_W));
	assign vel_o = jlaot_pkg::OVEL_W'(satw(p_vel, jlaot_pkg::OVEL_W));
	assign acc_o = jlaot_pkg::OACC_W'(satw(W'(acc_q) >>> SH, jlaot_pkg::OACC_W));
	assign sts.root_busy = rbusy_q;
	assign sts.div_busy  = dbusy_q;

`include "assert_macros.svh"
	`ASSERT_CLK(a_one_unit, clk, arst_n, !(rbusy_q && dbusy_q), "root and divider both busy")
	`ASSERT_NEXT(a_div_go, clk, arst_n, cmd.div_start, dbusy_q, "divider did not start")
	`ASSERT_CLK(a_div_once, clk, arst_n, !(cmd.div_start && dbusy_q), "divider restarted")
endmodule

// File: hw/rtl/jlaot_ctrl.sv
// Controller: sequences one tick through the datapath and the output register.
module jlaot_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output jlaot_pkg::jlaot_cmd_t cmd,
	input  jlaot_pkg::jlaot_sts_t sts,
	output logic                  cap
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RP = 4'd1, S_RS = 4'd2, S_RW = 4'd3,
		S_VT = 4'd4, S_JW = 4'd5, S_JD = 4'd6, S_AC = 4'd7, S_W1 = 4'd8, S_DV = 4'd9,
		S_W2 = 4'd10, S_D1 = 4'd11, S_W3 = 4'd12, S_D2 = 4'd13, S_UP = 4'd14,
		S_OUT = 4'd15;
	logic [3:0] st_q;
	logic ov_q, busy;

	assign busy = sts.div_busy || sts.root_busy;
	assign in_ready = st_q == S_IDLE;
	assign out_valid = ov_q;
	// The output register is loaded after the update; a tick waits only if it is full.
	assign cap = st_q == S_OUT && (!ov_q || out_ready);

	always_comb begin
		cmd.op = jlaot_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		unique case (st_q)
			S_IDLE: if (in_valid) cmd.op = jlaot_pkg::OP_LOAD;
			S_RP: cmd.op = jlaot_pkg::OP_ROOTP;
			S_RS: cmd.op = jlaot_pkg::OP_ROOT;
			S_VT: cmd.op = jlaot_pkg::OP_VT;
			S_JW: cmd.div_start = 1'b1;
			S_JD: if (!busy) cmd.op = jlaot_pkg::OP_JD;
			S_AC: cmd.op = jlaot_pkg::OP_ACC;
			S_W1: cmd.div_start = 1'b1;
			S_DV: if (!busy) cmd.op = jlaot_pkg::OP_DV;
			S_W2: cmd.div_start = 1'b1;
			S_D1: if (!busy) cmd.op = jlaot_pkg::OP_DP1;
			S_W3: cmd.div_start = 1'b1;
			S_D2: if (!busy) cmd.op = jlaot_pkg::OP_DP2;
			S_UP: cmd.op = jlaot_pkg::OP_UPD;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (cap) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid) st_q <= S_RP;
				S_RP: st_q <= S_RS;
				S_RS: st_q <= S_RW;
				S_RW: if (!busy) st_q <= S_VT;
				S_VT: st_q <= S_JW;
				S_JW: st_q <= S_JD;
				S_JD: if (!busy) st_q <= S_AC;
				S_AC: st_q <= S_W1;
				S_W1: st_q <= S_DV;
				S_DV: if (!busy) st_q <= S_W2;
				S_W2: st_q <= S_D1;
				S_D1: if (!busy) st_q <= S_W3;
				S_W3: st_q <= S_D2;
				S_D2: if (!busy) st_q <= S_UP;
				S_UP: st_q <= S_OUT;
				S_OUT: if (cap) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

`include "assert_macros.svh"
	`ASSERT_NEXT(a_cap_valid, clk, arst_n, cap, ov_q, "captured word not valid")
	`ASSERT_CLK(a_idle_free, clk, arst_n, !(st_q == S_IDLE && busy), "unit busy while idle")
	`ASSERT_NEXT(a_accept, clk, arst_n, in_valid && in_ready, st_q == S_RP, "no start")
endmodule

// File: hw/rtl/jerk_limited_altitude_offset_tracker.sv
// Top level of the jerk-limited altitude offset tracker.
// Channel | Signals                         | Word
// s_axis  | s_axis_tvalid/tready/tdata[31:0] | alt_offset_cm [24:0]
// m_axis  | m_axis_tvalid/tready/tdata[71:0] | pos_offset, vel_offset, accel_offset
// cfg     | cfg_we, cfg_idx, cfg_wdata       | register write
// Each accepted word runs to completion before the next is taken: a 65-step square root
// (skipped when the error is in the linear region) and four reciprocal divisions by one
// million run one after another on shared units.
// Reset clears the position, velocity and acceleration state and loads the register defaults.
// A full output register stalls the next result; input waits while busy.
module jerk_limited_altitude_offset_tracker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // alt_offset_cm[24:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // pos_offset[32:0], vel_offset[51:33], accel_offset[69:52]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [16:0] cfg_wdata
);
	jlaot_pkg::jlaot_cmd_t cmd;
	jlaot_pkg::jlaot_sts_t sts;
	logic [8:0]  amax_q, desc_q;
	logic [9:0]  climb_q;
	logic [16:0] dt_q;
	logic        cap;
	logic signed [jlaot_pkg::IN_W-1:0] alt_q;
	logic signed [jlaot_pkg::OPOS_W-1:0] pos_w;
	logic signed [jlaot_pkg::OVEL_W-1:0] vel_w;
	logic signed [jlaot_pkg::OACC_W-1:0] acc_w;
	logic [69:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amax_q <= 9'd100; climb_q <= 10'd250; desc_q <= 9'd150; dt_q <= 17'd10000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				jlaot_pkg::REG_AMAX:  amax_q  <= cfg_wdata[8:0];
				jlaot_pkg::REG_CLIMB: climb_q <= cfg_wdata[9:0];
				jlaot_pkg::REG_DESC:  desc_q  <= cfg_wdata[8:0];
				jlaot_pkg::REG_DT:    dt_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) alt_q <= s_axis_tdata[24:0];
		if (cap) out_q <= {acc_w, vel_w, pos_w};
	end

	jlaot_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd, .sts, .cap
	);

	jlaot_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.alt(s_axis_tvalid && s_axis_tready ? s_axis_tdata[24:0] : alt_q),
		.amax(amax_q), .climb(climb_q), .desc(desc_q), .dt(dt_q),
		.pos_o(pos_w), .vel_o(vel_w), .acc_o(acc_w)
	);

	assign m_axis_tdata = {2'b00, out_q};
endmodule
